// ----- design/gmspc_pkg.sv -----
// ----------------------------------------------------------------------------
// gmspc_pkg
// Shared types, constants and functions of the grid max-score path counter.
// ----------------------------------------------------------------------------
package gmspc_pkg;

    localparam int MAX_SIDE_DEF = 128;

    localparam int KIND_W   = 2;
    localparam int DIGIT_W  = 4;
    localparam int SCORE_W  = 12;
    localparam int COUNT_W  = 30;
    localparam int SIDE_W   = 8;

    localparam logic [KIND_W-1:0]  KIND_DIGIT    = 2'd0;
    localparam logic [KIND_W-1:0]  KIND_OBSTACLE = 2'd1;

    localparam logic [SIDE_W-1:0]  SIDE_RESET = 8'd2;
    localparam logic [COUNT_W-1:0] COUNT_MOD  = 30'd1000000007;
    localparam logic [SCORE_W-1:0] SCORE_MAX  = 12'd4095;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [COUNT_W-1:0] count;
    } entry_t;

    function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, COUNT_MOD})
        begin
            s = s - {1'b0, COUNT_MOD};
        end
        return s[COUNT_W-1:0];
    endfunction

endpackage

// ----- design/gmspc_ifs.sv -----
// ----------------------------------------------------------------------------
// gmspc channel interfaces
// Valid/ready channels for configuration, grid cells and results.
// ----------------------------------------------------------------------------
interface gmspc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [gmspc_pkg::SIDE_W-1:0]  grid_side;

    modport source (output valid, output grid_side, input ready);
    modport sink   (input valid, input grid_side, output ready);
endinterface

interface gmspc_cell_if;
    logic                          valid;
    logic                          ready;
    logic [gmspc_pkg::KIND_W-1:0]  cell_kind;
    logic [gmspc_pkg::DIGIT_W-1:0] digit_value;

    modport source (output valid, output cell_kind, output digit_value, input ready);
    modport sink   (input valid, input cell_kind, input digit_value, output ready);
endinterface

interface gmspc_result_if;
    logic                          valid;
    logic                          ready;
    logic [gmspc_pkg::SCORE_W-1:0] best_score;
    logic [gmspc_pkg::COUNT_W-1:0] path_count;

    modport source (output valid, output best_score, output path_count, input ready);
    modport sink   (input valid, input best_score, input path_count, output ready);
endinterface

// ----- design/gmspc_line_cell.sv -----
// ----------------------------------------------------------------------------
// gmspc_line_cell
// One stage of the row line: loads a new entry or takes its neighbor's.
// ----------------------------------------------------------------------------
module gmspc_line_cell
(
    input  logic              clk,
    input  logic              shift,
    input  logic              load_sel,
    input  gmspc_pkg::entry_t new_data,
    input  gmspc_pkg::entry_t prev_data,
    output gmspc_pkg::entry_t data
);

    gmspc_pkg::entry_t data_reg;
    gmspc_pkg::entry_t data_next;

    always_comb
    begin
        data_next = load_sel ? new_data : prev_data;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

// ----- design/gmspc_line_buf.sv -----
// ----------------------------------------------------------------------------
// gmspc_line_buf
// Chain of cells holding the previous grid row; the entry point sets the
// effective length so the up neighbor always sits in the last cell.
// ----------------------------------------------------------------------------
module gmspc_line_buf
#(
    parameter int MAX_SIDE = gmspc_pkg::MAX_SIDE_DEF,
    localparam int IW      = $clog2(MAX_SIDE)
)
(
    input  logic              clk,
    input  logic              shift,
    input  logic [IW-1:0]     entry_idx,
    input  gmspc_pkg::entry_t wr_data,
    output gmspc_pkg::entry_t rd_data
);

    gmspc_pkg::entry_t stage [MAX_SIDE];

    for (genvar i = 0; i < MAX_SIDE; i++)
    begin : g_cell
        gmspc_pkg::entry_t prev;

        if (i == 0)
        begin : g_first
            assign prev = wr_data;
        end
        else
        begin : g_rest
            assign prev = stage[i-1];
        end

        gmspc_line_cell u_cell
        (
            .clk       (clk),
            .shift     (shift),
            .load_sel  (entry_idx == IW'(i)),
            .new_data  (wr_data),
            .prev_data (prev),
            .data      (stage[i])
        );
    end

    assign rd_data = stage[MAX_SIDE-1];

endmodule

// ----- design/grid_max_score_path_count.sv -----
// ----------------------------------------------------------------------------
// grid_max_score_path_count
// Streams grid cells in raster order and reports the best path score and
// the number of best paths (mod 1e9+7) at the bottom-right cell.
//
//   port       role   carries
//   cfg        sink   grid_side (8b), restarts the grid
//   grid_cell  sink   cell_kind (2b), digit_value (4b)
//   result     source best_score (12b), path_count (30b), one per grid
//
// One cell per cycle while grid_cell.ready is high; the result is
// registered as the last cell is taken. The left neighbor feedback loop
// closes through left_*_reg; the previous row is a chain of MAX_SIDE cells.
// Reset clears position and neighbor state; the row chain needs no clear.
// grid_cell.ready drops only while a result is held and result.ready is low.
// ----------------------------------------------------------------------------
module grid_max_score_path_count
#(
    parameter int MAX_SIDE = gmspc_pkg::MAX_SIDE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    gmspc_cfg_if.sink             cfg,
    gmspc_cell_if.sink            grid_cell,
    gmspc_result_if.source        result
);

    localparam int IW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);

    logic [gmspc_pkg::SIDE_W-1:0]  grid_side_reg;
    logic [IW-1:0]                 row_reg;
    logic [IW-1:0]                 col_reg;
    logic [gmspc_pkg::SCORE_W-1:0] left_score_reg;
    logic [gmspc_pkg::COUNT_W-1:0] left_count_reg;
    logic [gmspc_pkg::SCORE_W-1:0] diag_score_reg;
    logic [gmspc_pkg::COUNT_W-1:0] diag_count_reg;
    logic                          out_valid_reg;
    logic [gmspc_pkg::SCORE_W-1:0] out_score_reg;
    logic [gmspc_pkg::COUNT_W-1:0] out_count_reg;

    logic [31:0]                   side_wide;
    logic [SW-1:0]                 eff_side;
    logic [IW-1:0]                 entry_idx;
    logic                          cell_acc;
    logic                          last_col;
    logic                          last_row;

    gmspc_pkg::entry_t             up_entry;
    gmspc_pkg::entry_t             new_entry;

    logic [gmspc_pkg::SCORE_W-1:0] us, ls, ds, best;
    logic [gmspc_pkg::COUNT_W-1:0] uc, lc, dc, sum;
    logic [gmspc_pkg::SCORE_W:0]   raw_score;
    logic [gmspc_pkg::SCORE_W-1:0] score_next;
    logic [gmspc_pkg::COUNT_W-1:0] count_next;

    assign cfg.ready       = 1'b1;
    assign grid_cell.ready = result.ready || !out_valid_reg;
    assign cell_acc        = grid_cell.valid && grid_cell.ready;

    always_comb
    begin
        side_wide = 32'(grid_side_reg);
        if (side_wide == 32'd0)
        begin
            eff_side = SW'(1);
        end
        else if (side_wide > 32'(MAX_SIDE))
        begin
            eff_side = SW'(MAX_SIDE);
        end
        else
        begin
            eff_side = SW'(side_wide);
        end
    end

    assign entry_idx = IW'(SW'(MAX_SIDE) - eff_side);
    assign last_col  = (SW'(col_reg) == eff_side - SW'(1));
    assign last_row  = (SW'(row_reg) == eff_side - SW'(1));

    always_comb
    begin
        us = '0;
        uc = '0;
        ls = '0;
        lc = '0;
        ds = '0;
        dc = '0;
        if (row_reg != '0)
        begin
            us = up_entry.score;
            uc = up_entry.count;
        end
        if (col_reg != '0)
        begin
            ls = left_score_reg;
            lc = left_count_reg;
        end
        if (row_reg != '0 && col_reg != '0)
        begin
            ds = diag_score_reg;
            dc = diag_count_reg;
        end

        best = us;
        if (ls > best)
        begin
            best = ls;
        end
        if (ds > best)
        begin
            best = ds;
        end

        sum = (us == best) ? uc : '0;
        sum = gmspc_pkg::add_mod(sum, (ls == best) ? lc : '0);
        sum = gmspc_pkg::add_mod(sum, (ds == best) ? dc : '0);

        raw_score = {1'b0, best};
        if (grid_cell.cell_kind == gmspc_pkg::KIND_DIGIT)
        begin
            raw_score = raw_score + (gmspc_pkg::SCORE_W + 1)'(grid_cell.digit_value);
        end

        if (grid_cell.cell_kind == gmspc_pkg::KIND_OBSTACLE)
        begin
            score_next = '0;
            count_next = '0;
        end
        else if (row_reg == '0 && col_reg == '0)
        begin
            score_next = '0;
            count_next = gmspc_pkg::COUNT_W'(1);
        end
        else
        begin
            count_next = sum;
            if (sum == '0)
            begin
                score_next = '0;
            end
            else if (raw_score[gmspc_pkg::SCORE_W])
            begin
                score_next = gmspc_pkg::SCORE_MAX;
            end
            else
            begin
                score_next = raw_score[gmspc_pkg::SCORE_W-1:0];
            end
        end

        new_entry.score = score_next;
        new_entry.count = count_next;
    end

    gmspc_line_buf
    #(
        .MAX_SIDE (MAX_SIDE)
    )
    u_line_buf
    (
        .clk       (clk),
        .shift     (cell_acc),
        .entry_idx (entry_idx),
        .wr_data   (new_entry),
        .rd_data   (up_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg  <= gmspc_pkg::SIDE_RESET;
            row_reg        <= '0;
            col_reg        <= '0;
            left_score_reg <= '0;
            left_count_reg <= '0;
            diag_score_reg <= '0;
            diag_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                grid_side_reg  <= cfg.grid_side;
                row_reg        <= '0;
                col_reg        <= '0;
                left_score_reg <= '0;
                left_count_reg <= '0;
                diag_score_reg <= '0;
                diag_count_reg <= '0;
            end
            else if (cell_acc)
            begin
                left_score_reg <= score_next;
                left_count_reg <= count_next;
                diag_score_reg <= us;
                diag_count_reg <= uc;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + IW'(1);
                end
                else
                begin
                    col_reg <= col_reg + IW'(1);
                end
            end

            if (cell_acc && last_col && last_row)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_acc && last_col && last_row)
        begin
            out_score_reg <= score_next;
            out_count_reg <= count_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.best_score = out_score_reg;
    assign result.path_count = out_count_reg;

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(col_reg) < eff_side)
        else $error("column index beyond grid side");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(row_reg) < eff_side)
        else $error("row index beyond grid side");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cell_acc && last_col && last_row |=> out_valid_reg)
        else $error("last cell did not produce a result");

    a_count_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_count_reg < gmspc_pkg::COUNT_MOD)
        else $error("path count not reduced");

    a_unreachable_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_count_reg == '0 |-> out_score_reg == '0)
        else $error("nonzero score with no paths");

endmodule

// ----- test/grid_max_score_path_count_test.sv -----
// ----------------------------------------------------------------------------
// grid_max_score_path_count_test
// Drives square grids through the path counter and checks every best-score /
// path-count transaction against a row-buffer model kept here or a typed
// result. A short table of hand-built grids comes first, then random grids
// of mostly small sides, then the first rows of a largest-side grid. Both
// handshakes idle at random; configuration is only written while drained.
// ----------------------------------------------------------------------------
module grid_max_score_path_count_test;

    localparam logic [gmspc_pkg::KIND_W-1:0] KIND_CORNER = 2'd2;
    localparam logic [gmspc_pkg::KIND_W-1:0] KIND_SPARE  = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_CELLS = 1550;
    localparam int CLAMP_CELLS  = 300;
    localparam int GAP_MAX      = 17;

    typedef enum int {STYLE_PLAIN, STYLE_TIES, STYLE_NOISE} grid_style_t;

    typedef struct packed {
        logic [gmspc_pkg::SCORE_W-1:0] best_score;
        logic [gmspc_pkg::COUNT_W-1:0] path_count;
    } path_result_t;

    // cells: one character per cell, row-major, right-aligned
    //   S corner, X obstacle, # unused kind, 0-9 a-f digit
    typedef struct packed {
        logic                          rewrite;
        logic [gmspc_pkg::SIDE_W-1:0]  side;
        logic [0:8][7:0]               cells;
        logic                          known;
        logic [gmspc_pkg::SCORE_W-1:0] score;
        logic [gmspc_pkg::COUNT_W-1:0] count;
    } grid_case_t;

    localparam grid_case_t DIRECTED_GRIDS [6] = '{
        '{1'b0, 8'd2, "S95S",      1'b1, 12'd9, 30'd1},
        '{1'b1, 8'd0, "X",         1'b1, 12'd0, 30'd0},
        '{1'b1, 8'd1, "9",         1'b1, 12'd0, 30'd1},
        '{1'b1, 8'd2, "0000",      1'b1, 12'd0, 30'd3},
        '{1'b1, 8'd2, "X555",      1'b1, 12'd0, 30'd0},
        '{1'b1, 8'd3, "Sf#X9ff0S", 1'b0, 12'd0, 30'd0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gmspc_cfg_if    cfg_ch();
    gmspc_cell_if   cell_ch();
    gmspc_result_if result_ch();

    grid_max_score_path_count dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_ch),
        .grid_cell (cell_ch),
        .result    (result_ch)
    );

    bit           idle_on = 1'b1;
    int           error_count = 0;
    int           cells_sent = 0;
    path_result_t expected_results[$];
    bit           use_typed = 1'b0;
    path_result_t typed_result;

    // row-buffer model state
    logic [gmspc_pkg::SIDE_W-1:0] side_reg;
    int unsigned       above_score [gmspc_pkg::MAX_SIDE_DEF];
    int unsigned       above_count [gmspc_pkg::MAX_SIDE_DEF];
    int unsigned       left_s, left_c, diag_s, diag_c;
    int unsigned       row_pos, col_pos;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int unsigned effective_span(input int unsigned value);
        if (value < 1)
        begin
            return 1;
        end
        if (value > gmspc_pkg::MAX_SIDE_DEF)
        begin
            return gmspc_pkg::MAX_SIDE_DEF;
        end
        return value;
    endfunction

    function automatic int unsigned mod_add(input int unsigned a, input int unsigned b);
        int unsigned s;
        s = a + b;
        return (s >= gmspc_pkg::COUNT_MOD) ? s - gmspc_pkg::COUNT_MOD : s;
    endfunction

    function automatic void load_side(input logic [gmspc_pkg::SIDE_W-1:0] value);
        side_reg = value;
        row_pos  = 0;
        col_pos  = 0;
        left_s   = 0;
        left_c   = 0;
        diag_s   = 0;
        diag_c   = 0;
    endfunction

    // returns 1 when the cell closes a grid; res then holds its transaction
    function automatic bit predict_cell(input logic [gmspc_pkg::KIND_W-1:0] kind,
                                        input logic [gmspc_pkg::DIGIT_W-1:0] digit,
                                        output path_result_t res);
        int unsigned span, r, c, score, total, top;
        int unsigned up_s, up_c, lf_s, lf_c, dg_s, dg_c;
        span = effective_span(side_reg);
        up_s = 0;
        up_c = 0;
        lf_s = 0;
        lf_c = 0;
        dg_s = 0;
        dg_c = 0;
        if (row_pos >= span)
        begin
            row_pos = 0;
        end
        if (col_pos >= span)
        begin
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        if (r > 0)
        begin
            up_s = above_score[c];
            up_c = above_count[c];
        end
        if (c > 0)
        begin
            lf_s = left_s;
            lf_c = left_c;
        end
        if (r > 0 && c > 0)
        begin
            dg_s = diag_s;
            dg_c = diag_c;
        end
        if (kind == gmspc_pkg::KIND_OBSTACLE)
        begin
            score = 0;
            total = 0;
        end
        else if (r == 0 && c == 0)
        begin
            score = 0;
            total = 1;
        end
        else
        begin
            top = up_s;
            if (lf_s > top)
            begin
                top = lf_s;
            end
            if (dg_s > top)
            begin
                top = dg_s;
            end
            total = 0;
            if (up_s == top)
            begin
                total = mod_add(total, up_c);
            end
            if (lf_s == top)
            begin
                total = mod_add(total, lf_c);
            end
            if (dg_s == top)
            begin
                total = mod_add(total, dg_c);
            end
            score = 0;
            if (total > 0)
            begin
                score = top + ((kind == gmspc_pkg::KIND_DIGIT) ? digit : 0);
                if (score > gmspc_pkg::SCORE_MAX)
                begin
                    score = gmspc_pkg::SCORE_MAX;
                end
            end
        end
        diag_s = up_s;
        diag_c = up_c;
        above_score[c] = score;
        above_count[c] = total;
        left_s = score;
        left_c = total;
        res.best_score = gmspc_pkg::SCORE_W'(score);
        res.path_count = gmspc_pkg::COUNT_W'(total);
        if (c + 1 < span)
        begin
            col_pos = c + 1;
            return 1'b0;
        end
        col_pos = 0;
        if (r + 1 < span)
        begin
            row_pos = r + 1;
            return 1'b0;
        end
        row_pos = 0;
        return 1'b1;
    endfunction

    function automatic void decode_char(input logic [7:0] ch,
                                        output logic [gmspc_pkg::KIND_W-1:0] kind,
                                        output logic [gmspc_pkg::DIGIT_W-1:0] digit);
        digit = '0;
        if (ch == "S")
        begin
            kind = KIND_CORNER;
        end
        else if (ch == "X")
        begin
            kind = gmspc_pkg::KIND_OBSTACLE;
        end
        else if (ch == "#")
        begin
            kind = KIND_SPARE;
        end
        else if (ch >= "a")
        begin
            kind  = gmspc_pkg::KIND_DIGIT;
            digit = gmspc_pkg::DIGIT_W'(ch - "a" + 8'd10);
        end
        else
        begin
            kind  = gmspc_pkg::KIND_DIGIT;
            digit = gmspc_pkg::DIGIT_W'(ch - "0");
        end
    endfunction

    function automatic void make_cell(input grid_style_t style, input bit at_corner,
                                      output logic [gmspc_pkg::KIND_W-1:0] kind,
                                      output logic [gmspc_pkg::DIGIT_W-1:0] digit);
        int pick;
        digit = (style == STYLE_TIES) ? gmspc_pkg::DIGIT_W'($urandom_range(0, 1))
                                      : gmspc_pkg::DIGIT_W'($urandom_range(0, 15));
        pick  = $urandom_range(0, 31);
        if (style == STYLE_NOISE)
        begin
            kind = gmspc_pkg::KIND_W'($urandom_range(0, 3));
        end
        else if (at_corner && pick > 7)
        begin
            kind = KIND_CORNER;
        end
        else if (pick < 2)
        begin
            kind = gmspc_pkg::KIND_OBSTACLE;
        end
        else if (pick == 2)
        begin
            kind = KIND_CORNER;
        end
        else if (pick == 3)
        begin
            kind = KIND_SPARE;
        end
        else
        begin
            kind = gmspc_pkg::KIND_DIGIT;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    // all drive tasks are entered and left at a falling edge
    task automatic push_cell(input logic [gmspc_pkg::KIND_W-1:0] kind,
                             input logic [gmspc_pkg::DIGIT_W-1:0] digit);
        int           gap;
        path_result_t res;
        gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cell_ch.valid       <= 1'b1;
        cell_ch.cell_kind   <= kind;
        cell_ch.digit_value <= digit;
        do
            @(posedge clk);
        while (!cell_ch.ready);
        if (predict_cell(kind, digit, res))
        begin
            expected_results.push_back(use_typed ? typed_result : res);
        end
        @(negedge clk);
    endtask

    task automatic wait_idle();
        cell_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_side(input logic [gmspc_pkg::SIDE_W-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.grid_side <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        load_side(value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic feed_cells(input grid_style_t style, input int span, input int cells);
        logic [gmspc_pkg::KIND_W-1:0]  kind;
        logic [gmspc_pkg::DIGIT_W-1:0] digit;
        for (int i = 0; i < cells; i++)
        begin
            make_cell(style, i == 0 || i == span * span - 1, kind, digit);
            push_cell(kind, digit);
            cells_sent++;
        end
    endtask

    initial
    begin
        path_result_t want;
        int           stall;
        result_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transaction score %0d count %0d",
                                          result_ch.best_score, result_ch.path_count));
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_ch.best_score !== want.best_score)
                begin
                    report_mismatch($sformatf("best_score %0d, expected %0d",
                                              result_ch.best_score, want.best_score));
                end
                if (result_ch.path_count !== want.path_count)
                begin
                    report_mismatch($sformatf("path_count %0d, expected %0d",
                                              result_ch.path_count, want.path_count));
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        logic [gmspc_pkg::KIND_W-1:0]  kind;
        logic [gmspc_pkg::DIGIT_W-1:0] digit;
        logic [gmspc_pkg::SIDE_W-1:0]  side_val;
        grid_style_t        style;
        int                 span, pick;
        cfg_ch.valid        = 1'b0;
        cfg_ch.grid_side    = '0;
        cell_ch.valid       = 1'b0;
        cell_ch.cell_kind   = '0;
        cell_ch.digit_value = '0;
        load_side(gmspc_pkg::SIDE_RESET);
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_GRIDS[i])
        begin
            if (DIRECTED_GRIDS[i].rewrite)
            begin
                wait_idle();
                write_side(DIRECTED_GRIDS[i].side);
            end
            use_typed    = DIRECTED_GRIDS[i].known;
            typed_result = '{DIRECTED_GRIDS[i].score, DIRECTED_GRIDS[i].count};
            for (int k = 0; k < 9; k++)
            begin
                if (DIRECTED_GRIDS[i].cells[k] != 8'd0)
                begin
                    decode_char(DIRECTED_GRIDS[i].cells[k], kind, digit);
                    push_cell(kind, digit);
                end
            end
            use_typed = 1'b0;
        end

        cells_sent = 0;
        while (cells_sent < RANDOM_CELLS)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
            begin
                side_val = 8'd0;
            end
            else if (pick == 1)
            begin
                side_val = 8'd1;
            end
            else if (pick < 11)
            begin
                side_val = gmspc_pkg::SIDE_W'($urandom_range(2, 3));
            end
            else
            begin
                side_val = gmspc_pkg::SIDE_W'($urandom_range(4, 9));
            end
            wait_idle();
            write_side(side_val);
            span    = effective_span(side_val);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 5))
            begin
                pick  = $urandom_range(0, 9);
                style = (pick == 0) ? STYLE_NOISE : (pick < 3) ? STYLE_TIES : STYLE_PLAIN;
                feed_cells(style, span, span * span);
            end
            // partial grid, cut short by the next write
            if (span > 1 && $urandom_range(0, 7) == 0)
            begin
                feed_cells(STYLE_PLAIN, span, $urandom_range(1, span * span - 1));
            end
        end

        // side above the limit, first rows only
        wait_idle();
        write_side(8'hFF);
        idle_on = 1'b0;
        feed_cells(STYLE_TIES, gmspc_pkg::MAX_SIDE_DEF, CLAMP_CELLS);
        idle_on = 1'b1;

        wait_idle();
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/gmspc_pkg.sv
design/gmspc_ifs.sv
design/gmspc_line_cell.sv
design/gmspc_line_buf.sv
design/grid_max_score_path_count.sv
test/grid_max_score_path_count_test.sv
